@@ design/hbbc_pkg.sv @@
package hbbc_pkg;

   typedef enum logic [1:0] {
      FUNC_READ    = 2'd0,
      FUNC_RELEASE = 2'd1,
      FUNC_PIN     = 2'd2,
      FUNC_UNPIN   = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NO_FREE   = 2'd1,
      STATUS_UNDERFLOW = 2'd2,
      STATUS_OVERFLOW  = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_HASH,
      ST_SEARCH,
      ST_HIT,
      ST_SCAN_HEAD,
      ST_SCAN,
      ST_UNLINK,
      ST_PUSH,
      ST_ADJUST,
      ST_DONE
   } state_type;

   localparam logic [7:0] REF_MAX = 8'd255;

   // controller -> datapath
   typedef struct packed {
      logic load;         // latch request
      logic search_init;  // cursor <= head of hashed bucket
      logic search_step;  // cursor <= next
      logic scan_head;    // cursor <= head of scan bucket
      logic scan_step;    // cursor <= next in scan bucket
      logic scan_bucket;  // advance to next bucket
      logic do_hit;
      logic do_unlink;
      logic do_push;
      logic do_adjust;
      logic set_no_free;
      logic respond;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_read;
      logic cur_nil;
      logic steps_done;
      logic tag_match;
      logic cur_free;
      logic buckets_done;
   } stat_type;

endpackage

@@ design/hbbc_datapath.sv @@
module hbbc_datapath #(
   parameter int NUM_BUFFERS = 32,
   parameter int NUM_BUCKETS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [1:0]            req_func,
   input  logic [7:0]            req_device,
   input  logic [31:0]           req_block_number,
   input  logic [4:0]            req_buffer_index,
   input  hbbc_pkg::cmd_type     cmd,
   output hbbc_pkg::stat_type    stat,
   output logic                  rsp_valid,
   output logic [4:0]            rsp_granted_buffer,
   output logic                  rsp_hit,
   output logic                  rsp_need_disk_read,
   output logic [1:0]            rsp_status
);
   import hbbc_pkg::*;

   localparam int LW = $clog2(NUM_BUFFERS + 1);
   localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
   localparam int IW = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
   localparam int KW = $clog2(NUM_BUCKETS + 1);
   localparam logic [LW-1:0] NIL = LW'(NUM_BUFFERS);

   logic [7:0]    tag_device_ff [NUM_BUFFERS];
   logic [31:0]   tag_block_ff  [NUM_BUFFERS];
   logic          valid_ff      [NUM_BUFFERS];
   logic [7:0]    ref_ff        [NUM_BUFFERS];
   logic [LW-1:0] next_ff       [NUM_BUFFERS];
   logic [LW-1:0] prev_ff       [NUM_BUFFERS];
   logic [BW-1:0] owner_ff      [NUM_BUFFERS];
   logic [LW-1:0] first_ff      [NUM_BUCKETS];

   logic [1:0]    func_ff;
   logic [7:0]    dev_ff;
   logic [31:0]   blk_ff;
   logic [4:0]    idx_ff;
   logic [BW-1:0] hash_ff;
   logic [LW-1:0] cur_ff;
   logic [LW-1:0] steps_ff;
   logic [KW-1:0] bucket_ff;

   logic          rsp_valid_ff;
   logic [4:0]    granted_ff;
   logic          hit_ff, need_ff;
   logic [1:0]    status_ff;

   logic [31:0]   sum;
   logic [IW-1:0] cur_i;
   logic [IW-1:0] idx_i;
   logic          idx_ok;
   logic [LW-1:0] cur_next;

   assign sum      = 32'(req_device) + req_block_number;
   assign cur_i    = cur_ff[IW-1:0];
   assign idx_i    = IW'(idx_ff);
   assign idx_ok   = 32'(idx_ff) < NUM_BUFFERS;
   assign cur_next = next_ff[cur_i];

   assign stat.is_read      = func_ff == FUNC_READ;
   assign stat.cur_nil      = cur_ff >= NIL;
   assign stat.steps_done   = steps_ff >= NIL;
   assign stat.tag_match    = tag_device_ff[cur_i] == dev_ff && tag_block_ff[cur_i] == blk_ff;
   assign stat.cur_free     = ref_ff[cur_i] == 8'd0;
   assign stat.buckets_done = 32'(bucket_ff) >= NUM_BUCKETS;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= req_func;
         dev_ff  <= req_device;
         blk_ff  <= req_block_number;
         idx_ff  <= req_buffer_index;
         hash_ff <= BW'(sum % NUM_BUCKETS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff    <= NIL;
         steps_ff  <= '0;
         bucket_ff <= '0;
      end else if (cmd.search_init) begin
         cur_ff   <= first_ff[hash_ff];
         steps_ff <= '0;
      end else if (cmd.search_step || cmd.scan_step) begin
         cur_ff   <= cur_next;
         steps_ff <= steps_ff + 1'b1;
      end else if (cmd.scan_head) begin
         cur_ff    <= first_ff[bucket_ff[BW-1:0]];
         steps_ff  <= '0;
      end else if (cmd.load) begin
         bucket_ff <= '0;
      end else if (cmd.scan_bucket) begin
         bucket_ff <= bucket_ff + 1'b1;
      end
   end

   // directory state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_BUFFERS; i++) begin
            tag_device_ff[i] <= '0;
            tag_block_ff[i]  <= '0;
            valid_ff[i]      <= 1'b0;
            ref_ff[i]        <= '0;
            owner_ff[i]      <= BW'(i % NUM_BUCKETS);
            next_ff[i]       <= (i >= NUM_BUCKETS) ? LW'(i - NUM_BUCKETS) : NIL;
            prev_ff[i]       <= (i + NUM_BUCKETS < NUM_BUFFERS) ? LW'(i + NUM_BUCKETS) : NIL;
         end
         for (int k = 0; k < NUM_BUCKETS; k++) begin
            first_ff[k] <= (k < NUM_BUFFERS)
               ? LW'(k + ((NUM_BUFFERS - 1 - k) / NUM_BUCKETS) * NUM_BUCKETS) : NIL;
         end
      end else begin
         // a hit on a saturated count leaves the entry alone
         if (cmd.do_hit && ref_ff[cur_i] != REF_MAX) begin
            ref_ff[cur_i]   <= ref_ff[cur_i] + 8'd1;
            valid_ff[cur_i] <= 1'b1;
         end
         if (cmd.do_unlink) begin
            if (prev_ff[cur_i] < NIL) next_ff[prev_ff[cur_i][IW-1:0]] <= next_ff[cur_i];
            else first_ff[owner_ff[cur_i]] <= next_ff[cur_i];
            if (next_ff[cur_i] < NIL) prev_ff[next_ff[cur_i][IW-1:0]] <= prev_ff[cur_i];
         end
         if (cmd.do_push) begin
            next_ff[cur_i]       <= first_ff[hash_ff];
            prev_ff[cur_i]       <= NIL;
            if (first_ff[hash_ff] < NIL) prev_ff[first_ff[hash_ff][IW-1:0]] <= cur_ff;
            first_ff[hash_ff]    <= cur_ff;
            owner_ff[cur_i]      <= hash_ff;
            tag_device_ff[cur_i] <= dev_ff;
            tag_block_ff[cur_i]  <= blk_ff;
            valid_ff[cur_i]      <= 1'b1;
            ref_ff[cur_i]        <= 8'd1;
         end
         if (cmd.do_adjust && idx_ok) begin
            if (func_ff == FUNC_PIN) begin
               if (ref_ff[idx_i] != REF_MAX) ref_ff[idx_i] <= ref_ff[idx_i] + 8'd1;
            end else if (ref_ff[idx_i] != 8'd0) begin
               ref_ff[idx_i] <= ref_ff[idx_i] - 8'd1;
            end
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.respond;
      end
      if (cmd.load) begin
         granted_ff <= '0;
         hit_ff     <= 1'b0;
         need_ff    <= 1'b0;
         status_ff  <= STATUS_OK;
      end
      if (cmd.do_hit) begin
         if (ref_ff[cur_i] == REF_MAX) begin
            status_ff <= STATUS_OVERFLOW;
         end else begin
            granted_ff <= 5'(cur_ff);
            hit_ff     <= 1'b1;
            need_ff    <= !valid_ff[cur_i];
         end
      end
      if (cmd.do_push) begin
         granted_ff <= 5'(cur_ff);
         need_ff    <= 1'b1;
      end
      if (cmd.set_no_free) status_ff <= STATUS_NO_FREE;
      if (cmd.do_adjust && idx_ok) begin
         if (func_ff == FUNC_PIN) begin
            if (ref_ff[idx_i] == REF_MAX) status_ff <= STATUS_OVERFLOW;
         end else if (ref_ff[idx_i] == 8'd0) begin
            status_ff <= STATUS_UNDERFLOW;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_granted_buffer = granted_ff;
   assign rsp_hit            = hit_ff;
   assign rsp_need_disk_read = need_ff;
   assign rsp_status         = status_ff;

endmodule

@@ design/hbbc_ctrl.sv @@
module hbbc_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  hbbc_pkg::stat_type stat,
   output hbbc_pkg::cmd_type  cmd
);
   import hbbc_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = state_ff != ST_IDLE;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_HASH;
            end
         end
         ST_HASH: begin
            if (stat.is_read) begin
               cmd.search_init = 1'b1;
               state_in = ST_SEARCH;
            end else begin
               state_in = ST_ADJUST;
            end
         end
         ST_SEARCH: begin
            if (stat.cur_nil || stat.steps_done) begin
               state_in = ST_SCAN_HEAD;
            end else if (stat.tag_match) begin
               state_in = ST_HIT;
            end else begin
               cmd.search_step = 1'b1;
            end
         end
         ST_HIT: begin
            cmd.do_hit = 1'b1;
            state_in = ST_DONE;
         end
         ST_SCAN_HEAD: begin
            if (stat.buckets_done) begin
               cmd.set_no_free = 1'b1;
               state_in = ST_DONE;
            end else begin
               cmd.scan_head = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (stat.cur_nil || stat.steps_done) begin
               cmd.scan_bucket = 1'b1;
               state_in = ST_SCAN_HEAD;
            end else if (stat.cur_free) begin
               state_in = ST_UNLINK;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_UNLINK: begin
            cmd.do_unlink = 1'b1;
            state_in = ST_PUSH;
         end
         ST_PUSH: begin
            cmd.do_push = 1'b1;
            state_in = ST_DONE;
         end
         ST_ADJUST: begin
            cmd.do_adjust = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            cmd.respond = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

@@ design/hashed_block_buffer_cache.sv @@
// Channel  | Ports                                         | Handshake
// request  | req_func, req_device, req_block_number,       | start & !busy
//          | req_buffer_index                              |
// result   | rsp_granted_buffer, rsp_hit,                  | rsp_valid, one cycle
//          | rsp_need_disk_read, rsp_status                |
// Release/pin/unpin go from start through hash and adjust to the result; a read
// walks the hashed bucket and, on a hit, counts the buffer. A miss adds the victim
// scan, bucket by bucket with the single list cursor, then unlink and push of the
// victim into the hashed bucket.
// Synchronous reset rebuilds the initial bucket lists.
// busy drops in the result cycle, so the next request can be taken at the edge that
// takes the result; results cannot be stalled.
module hashed_block_buffer_cache #(
   parameter int NUM_BUFFERS = 32,
   parameter int NUM_BUCKETS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_func,
   input  logic [7:0]  req_device,
   input  logic [31:0] req_block_number,
   input  logic [4:0]  req_buffer_index,
   output logic        rsp_valid,
   output logic [4:0]  rsp_granted_buffer,
   output logic        rsp_hit,
   output logic        rsp_need_disk_read,
   output logic [1:0]  rsp_status
);
   import hbbc_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   hbbc_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   hbbc_datapath #(
      .NUM_BUFFERS (NUM_BUFFERS),
      .NUM_BUCKETS (NUM_BUCKETS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_func           (req_func),
      .req_device         (req_device),
      .req_block_number   (req_block_number),
      .req_buffer_index   (req_buffer_index),
      .cmd                (cmd),
      .stat               (stat),
      .rsp_valid          (rsp_valid),
      .rsp_granted_buffer (rsp_granted_buffer),
      .rsp_hit            (rsp_hit),
      .rsp_need_disk_read (rsp_need_disk_read),
      .rsp_status         (rsp_status)
   );

   a_rsp_when_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy)) else $error("result without request");

   a_rsp_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("busy after result");

   a_hit_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> rsp_status == STATUS_OK) else $error("hit with error");

   a_err_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> !rsp_hit && !rsp_need_disk_read
      && rsp_granted_buffer == 5'd0) else $error("error result not cleared");

endmodule

@@ bench/hashed_block_buffer_cache_checker.sv @@
`timescale 1ns / 1ps

module hashed_block_buffer_cache_checker #(
   parameter int NUM_BUFFERS = 32,
   parameter int NUM_BUCKETS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [1:0]  req_func,
   input  logic [7:0]  req_device,
   input  logic [31:0] req_block_number,
   input  logic [4:0]  req_buffer_index,
   input  logic        rsp_valid,
   input  logic [4:0]  rsp_granted_buffer,
   input  logic        rsp_hit,
   input  logic        rsp_need_disk_read,
   input  logic [1:0]  rsp_status,
   output int          fail_count,
   output int          pending_count
);
   import hbbc_pkg::*;

   localparam int NIL = NUM_BUFFERS;

   typedef struct packed {
      logic [4:0] granted;
      logic       hit;
      logic       need;
      status_type status;
   } outcome_type;

   logic [7:0]  dev_tag  [NUM_BUFFERS];
   logic [31:0] blk_tag  [NUM_BUFFERS];
   logic        valid_q  [NUM_BUFFERS];
   logic [7:0]  refs     [NUM_BUFFERS];
   int          nxt      [NUM_BUFFERS];
   int          prv      [NUM_BUFFERS];
   int          owner    [NUM_BUFFERS];
   int          head     [NUM_BUCKETS];
   outcome_type expected_q[$];

   function automatic void push_head(int bk, int b);
      nxt[b] = head[bk];
      prv[b] = NIL;
      if (head[bk] < NIL) prv[head[bk]] = b;
      head[bk] = b;
      owner[b] = bk;
   endfunction

   function automatic void clear_cache();
      for (int i = 0; i < NUM_BUCKETS; i++) head[i] = NIL;
      for (int i = 0; i < NUM_BUFFERS; i++) begin
         dev_tag[i] = '0;
         blk_tag[i] = '0;
         valid_q[i] = 1'b0;
         refs[i] = '0;
         push_head(i % NUM_BUCKETS, i);
      end
   endfunction

   function automatic outcome_type predict_lookup(logic [1:0] fn, logic [7:0] dev,
                                                  logic [31:0] blk, logic [4:0] idx);
      outcome_type o;
      logic [31:0] sum;
      int h, b, c, steps, victim;
      bit found;
      o = '{granted: '0, hit: 1'b0, need: 1'b0, status: STATUS_OK};
      if (fn == FUNC_READ) begin
         sum = blk + 32'(dev);
         h = int'(sum % NUM_BUCKETS);
         b = head[h];
         steps = 0;
         found = 0;
         while (b < NIL && steps < NUM_BUFFERS) begin
            if (dev_tag[b] == dev && blk_tag[b] == blk) begin
               found = 1;
               break;
            end
            b = nxt[b];
            steps++;
         end
         if (found) begin
            if (refs[b] == REF_MAX) o.status = STATUS_OVERFLOW;
            else begin
               refs[b]++;
               o.hit = 1'b1;
               o.granted = b[4:0];
            end
         end else begin
            victim = NIL;
            for (int bk = 0; bk < NUM_BUCKETS && victim == NIL; bk++) begin
               c = head[bk];
               steps = 0;
               while (c < NIL && steps < NUM_BUFFERS) begin
                  if (refs[c] == 0) begin
                     victim = c;
                     break;
                  end
                  c = nxt[c];
                  steps++;
               end
            end
            if (victim == NIL) o.status = STATUS_NO_FREE;
            else begin
               if (prv[victim] < NIL) nxt[prv[victim]] = nxt[victim];
               else head[owner[victim]] = nxt[victim];
               if (nxt[victim] < NIL) prv[nxt[victim]] = prv[victim];
               dev_tag[victim] = dev;
               blk_tag[victim] = blk;
               valid_q[victim] = 1'b0;
               refs[victim] = 8'd1;
               push_head(h, victim);
               o.granted = victim[4:0];
               b = victim;
               found = 1;
            end
         end
         if (o.status == STATUS_OK && found && !valid_q[b]) begin
            o.need = 1'b1;
            valid_q[b] = 1'b1;
         end
      end else if (int'(idx) < NUM_BUFFERS) begin
         if (fn == FUNC_PIN) begin
            if (refs[idx] == REF_MAX) o.status = STATUS_OVERFLOW;
            else refs[idx]++;
         end else begin
            if (refs[idx] == 0) o.status = STATUS_UNDERFLOW;
            else refs[idx]--;
         end
      end
      return o;
   endfunction

   assign pending_count = expected_q.size();

   always @(posedge clock) begin
      outcome_type e;
      if (reset) begin
         clear_cache();
         expected_q.delete();
         fail_count <= 0;
      end else begin
         // a result and the next request may share an edge; check before queuing
         if (rsp_valid) begin
            if (expected_q.size() == 0) begin
               if (fail_count < 10) $display("unexpected result at %0t", $time);
               fail_count <= fail_count + 1;
            end else begin
               e = expected_q.pop_front();
               if (rsp_granted_buffer !== e.granted || rsp_hit !== e.hit ||
                   rsp_need_disk_read !== e.need || rsp_status !== e.status) begin
                  if (fail_count < 10)
                     $display("mismatch at %0t: exp buf %0d hit %0b need %0b st %0d, got %0d %0b %0b %0d",
                              $time, e.granted, e.hit, e.need, e.status, rsp_granted_buffer,
                              rsp_hit, rsp_need_disk_read, rsp_status);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (start && !busy)
            expected_q.push_back(predict_lookup(req_func, req_device, req_block_number,
                                                req_buffer_index));
      end
   end

endmodule

@@ bench/hashed_block_buffer_cache_tb.sv @@
`timescale 1ns / 1ps

module hashed_block_buffer_cache_tb;
   import hbbc_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_func = FUNC_READ;
   logic [7:0]  req_device = '0;
   logic [31:0] req_block_number = '0;
   logic [4:0]  req_buffer_index = '0;
   logic        rsp_valid;
   logic [4:0]  rsp_granted_buffer;
   logic        rsp_hit;
   logic        rsp_need_disk_read;
   logic [1:0]  rsp_status;
   int          fail_count;
   int          pending_count;
   int          cycles = 0;
   bit          calm = 0;

   always #1 clock = ~clock;

   hashed_block_buffer_cache dut (.*);

   hashed_block_buffer_cache_checker chk (.*);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 1000000) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // hold start until the request is taken; busy only moves at the rising edge
   task automatic send_request(func_type fn, logic [7:0] dev, logic [31:0] blk,
                               logic [4:0] idx);
      while (!calm && $urandom_range(99) < 27) @(negedge clock);
      req_func = fn;
      req_device = dev;
      req_block_number = blk;
      req_buffer_index = idx;
      start = 1'b1;
      while (busy) @(negedge clock);
      @(negedge clock);
      start = 1'b0;
   endtask

   task automatic send_read(logic [7:0] dev, logic [31:0] blk);
      send_request(FUNC_READ, dev, blk, 5'($urandom));
   endtask

   initial begin
      logic [7:0] dev;
      logic [31:0] blk;
      int n;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      // directed: initial tags, extremes, underflow
      send_read(8'd0, 32'd0);
      send_read(8'd0, 32'd0);
      send_read(8'hFF, 32'hFFFF_FFFF);
      send_read(8'hFF, 32'h0000_0001);
      send_request(FUNC_RELEASE, 8'd0, 32'd0, 5'd31);
      send_request(FUNC_UNPIN, 8'd0, 32'd0, 5'd31);
      send_request(FUNC_PIN, 8'hFF, 32'hFFFF_FFFF, 5'd31);
      send_request(FUNC_UNPIN, 8'd0, 32'd0, 5'd31);
      send_request(FUNC_UNPIN, 8'd0, 32'd0, 5'd5);
      // fill every buffer, then a miss finds nothing free
      for (int i = 0; i < 34; i++) send_read(8'h10, 32'(i * 3 + 100));
      send_read(8'h22, 32'hDEAD_BEEF);
      // overflow on buffer 7 by pinning
      for (int i = 0; i < 256; i++) begin
         calm = 1;
         send_request(FUNC_PIN, 8'd0, 32'd0, 5'd7);
      end
      calm = 0;
      send_read(8'h10, 32'd100);
      for (int i = 0; i < 32; i++) send_request(FUNC_UNPIN, 8'd0, 32'd0, 5'(i));
      for (int i = 0; i < 260; i++) send_request(FUNC_RELEASE, 8'd0, 32'd0, 5'd7);
      // random: half reads over a small working set, the rest release, pin and unpin on random indices
      for (int i = 0; i < 1300; i++) begin
         calm = (i >= 600 && i < 900);
         n = $urandom_range(99);
         dev = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(3));
         blk = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(40));
         if (n < 50) send_read(dev, blk);
         else if (n < 80) send_request(FUNC_RELEASE, dev, blk, 5'($urandom));
         else if (n < 88) send_request(FUNC_PIN, dev, blk, 5'($urandom));
         else send_request(FUNC_UNPIN, dev, blk, 5'($urandom));
      end
      while (pending_count != 0) @(posedge clock);
      repeat (150) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

endmodule
